@@ rtl/core/sbpd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_pkg
// Types and constants shared by the servo bus packet deframer modules.
// ----------------------------------------------------------------------------
package sbpd_pkg;

	localparam logic [7:0] HDR_SYNC    = 8'hFF;
	localparam logic [7:0] HDR_LAST    = 8'hFD;
	localparam logic [7:0] FRAME_LIMIT_RST = 8'd255;
	// Added to the effective length: index of the last parameter byte.
	localparam logic [16:0] PAR_OFFSET = 17'd4;
	localparam logic [15:0] MIN_LEN    = 16'd3;

	typedef enum logic [3:0] {
		PH_H0  = 4'd0,
		PH_H1  = 4'd1,
		PH_H2  = 4'd2,
		PH_RES = 4'd3,
		PH_ID  = 4'd4,
		PH_LLO = 4'd5,
		PH_LHI = 4'd6,
		PH_INS = 4'd7,
		PH_PAR = 4'd8,
		PH_CK1 = 4'd9,
		PH_CK2 = 4'd10
	} phase_t;

	typedef enum logic [3:0] {
		ROLE_DISCARD = 4'd0,
		ROLE_HEADER  = 4'd1,
		ROLE_RES     = 4'd2,
		ROLE_ID      = 4'd3,
		ROLE_LEN_LO  = 4'd4,
		ROLE_LEN_HI  = 4'd5,
		ROLE_INSTR   = 4'd6,
		ROLE_PARAM   = 4'd7,
		ROLE_CRC_LO  = 4'd8,
		ROLE_CRC_HI  = 4'd9,
		ROLE_NONE    = 4'd10
	} role_t;

	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_DONE = 2'd1,
		ST_OVF  = 2'd2,
		ST_TMO  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		role_t       role;
		logic [7:0]  byte_index;
		status_t     status;
		logic [15:0] declared_length;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/core/servo_bus_packet_deframer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// servo_bus_packet_deframer_top
// Tags received bytes with their role and frame position, ends frames.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | kind, rx_byte
//  out     | out_valid / out_stall  | data_byte, role, byte_index, status,
//          |                        | declared_length
//  cfg     | cfg_valid / cfg_ready  | cfg_data (frame_limit)
//
// One item per cycle while out_stall is low; an item is captured in the input
// register, passes once through the frame state machine and is loaded into the
// result register.
// Reset returns to header hunting with frame_limit at 255.
// out_stall, while out_valid is high, holds the result register and, once the input
// register is full, raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
module servo_bus_packet_deframer_top
	import sbpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       data_byte,
	output logic [3:0]       role,
	output logic [7:0]       byte_index,
	output logic [1:0]       status,
	output logic [15:0]      declared_length,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	logic       valid_s1, kind_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	res_t       res, res_q;
	logic [7:0] frame_limit_q;
	logic       out_ready, advance;

	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= FRAME_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			frame_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			byte_s1 <= rx_byte;
		end
	end

	sbpd_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.kind        (kind_s1),
		.rx_byte     (byte_s1),
		.frame_limit (frame_limit_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign data_byte       = res_q.data_byte;
	assign role            = res_q.role;
	assign byte_index      = res_q.byte_index;
	assign status          = res_q.status;
	assign declared_length = res_q.declared_length;

endmodule
`default_nettype wire

@@ rtl/core/sbpd_fsm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_fsm
// Frame state machine: tags one byte or timeout per step and updates state.
// ----------------------------------------------------------------------------
module sbpd_fsm
	import sbpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic       kind,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] frame_limit,
	output res_t            res
);

	phase_t      phase_q, phase_d, nx;
	logic [7:0]  count_q, count_d, idx;
	logic [15:0] len_q, len_d, len_new, eff;
	logic [8:0]  n;
	role_t       role;
	logic        done, ovf;

	// Decode the current byte against the current phase.
	always_comb begin
		len_new = len_q;
		role    = ROLE_DISCARD;
		idx     = 8'd0;
		nx      = PH_H0;
		done    = 1'b0;
		case (phase_q)
			PH_LLO: len_new = {8'h00, rx_byte};
			PH_LHI: len_new = {rx_byte, len_q[7:0]};
			default: len_new = len_q;
		endcase
		eff = (len_new < MIN_LEN) ? MIN_LEN : len_new;
		case (phase_q)
			PH_H1: begin
				if (rx_byte == HDR_SYNC) begin
					role = ROLE_HEADER;
					idx  = 8'd1;
					nx   = PH_H2;
				end
			end
			PH_H2: begin
				if (rx_byte == HDR_LAST) begin
					role = ROLE_HEADER;
					idx  = 8'd2;
					nx   = PH_RES;
				end else if (rx_byte == HDR_SYNC) begin
					// extra sync byte: hold position
					role = ROLE_HEADER;
					idx  = 8'd1;
					nx   = PH_H2;
				end
			end
			PH_RES: begin
				role = ROLE_RES;
				idx  = count_q;
				nx   = PH_ID;
			end
			PH_ID: begin
				role = ROLE_ID;
				idx  = count_q;
				nx   = PH_LLO;
			end
			PH_LLO: begin
				role = ROLE_LEN_LO;
				idx  = count_q;
				nx   = PH_LHI;
			end
			PH_LHI: begin
				role = ROLE_LEN_HI;
				idx  = count_q;
				nx   = PH_INS;
			end
			PH_INS: begin
				role = ROLE_INSTR;
				idx  = count_q;
				nx   = (eff == MIN_LEN) ? PH_CK1 : PH_PAR;
			end
			PH_PAR: begin
				role = ROLE_PARAM;
				idx  = count_q;
				nx   = ({9'd0, count_q} >= ({1'b0, eff} + PAR_OFFSET)) ? PH_CK1 : PH_PAR;
			end
			PH_CK1: begin
				role = ROLE_CRC_LO;
				idx  = count_q;
				nx   = PH_CK2;
			end
			PH_CK2: begin
				role = ROLE_CRC_HI;
				idx  = count_q;
				done = 1'b1;
			end
			default: begin
				// first header byte; unknown codes hunt as well
				if (rx_byte == HDR_SYNC) begin
					role = ROLE_HEADER;
					nx   = PH_H1;
				end
			end
		endcase
		n   = {1'b0, idx} + 9'd1;
		ovf = (n >= {1'b0, frame_limit});
	end

	// Next state.
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		len_d   = len_q;
		if (advance) begin
			if (kind || ovf || done || nx == PH_H0) begin
				phase_d = PH_H0;
				count_d = 8'd0;
				len_d   = 16'd0;
			end else begin
				phase_d = nx;
				count_d = n[7:0];
				len_d   = len_new;
			end
		end
	end

	// Result.
	always_comb begin
		if (kind) begin
			res.data_byte       = 8'd0;
			res.role            = ROLE_NONE;
			res.byte_index      = count_q;
			res.status          = ST_TMO;
			res.declared_length = len_q;
		end else begin
			res.data_byte       = rx_byte;
			res.role            = role;
			res.byte_index      = idx;
			res.status          = ovf ? ST_OVF : (done ? ST_DONE : ST_RUN);
			res.declared_length = len_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_H0;
			count_q <= 8'd0;
			len_q   <= 16'd0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			len_q   <= len_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/sbpd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sbpd_checker
	import sbpd_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  data_byte,
	input wire logic [3:0]  role,
	input wire logic [7:0]  byte_index,
	input wire logic [1:0]  status
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(role)
			&& $stable(byte_index) && $stable(status))
		else $error("stalled result changed");

	// A fresh result follows an item taken at the input.
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching item");

	// Timeouts and only timeouts carry role none with a zero byte.
	a_tmo_role: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_TMO) |-> (role == ROLE_NONE) && (data_byte == 8'd0))
		else $error("timeout result malformed");

	a_none_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (role == ROLE_NONE) |-> (status == ST_TMO))
		else $error("role none outside timeout");

	// Discarded bytes sit at position zero and never complete a frame.
	a_discard: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (role == ROLE_DISCARD) |-> (byte_index == 8'd0) && (status != ST_DONE))
		else $error("discarded byte misplaced");

endmodule

bind servo_bus_packet_deframer_top sbpd_checker u_sbpd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.data_byte  (data_byte),
	.role       (role),
	.byte_index (byte_index),
	.status     (status)
);
`default_nettype wire

@@ dv/servo_bus_packet_deframer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_bus_packet_deframer_top_tb
// Feeds byte and timeout items, computes the tag each one should get (role,
// frame position, status, length so far) and checks every result in order.
// Runs through several frame limits, with random idling on each side on or off per run.
// ----------------------------------------------------------------------------
module servo_bus_packet_deframer_top_tb;
	import sbpd_pkg::*;

	typedef struct packed {
		logic       kind;
		logic [7:0] b;
	} rx_ev_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  data_byte;
	logic [3:0]  role;
	logic [7:0]  byte_index;
	logic [1:0]  status;
	logic [15:0] declared_length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;

	// deframer state as this bench tracks it
	phase_t      fr_phase = PH_H0;
	logic [7:0]  fr_count = 8'h00;
	logic [15:0] fr_len = 16'h0000;
	logic [7:0]  fr_limit = FRAME_LIMIT_RST;

	rx_ev_t rx_stream[$];
	res_t   pending_tags[$];
	int     tag_errors = 0;
	bit     tx_idle_en = 1'b1;
	bit     rx_idle_en = 1'b1;
	int     tx_gap = 0;
	int     rx_gap = 0;
	logic   hold_start = 1'b0;
	int     hold_left = 0;

	servo_bus_packet_deframer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.role(role),
		.byte_index(byte_index),
		.status(status),
		.declared_length(declared_length),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic void restart_hunt();
		fr_phase = PH_H0;
		fr_count = 8'h00;
		fr_len = 16'h0000;
	endfunction

	// Tag one item and advance the tracked frame state.
	function automatic res_t tag_next_byte(input logic tmo, input logic [7:0] b);
		res_t        r;
		role_t       rl;
		phase_t      nxt;
		logic [7:0]  idx;
		logic [8:0]  cnt;
		logic [15:0] eff;
		logic        fin;
		if (tmo) begin
			r.data_byte = 8'h00;
			r.role = ROLE_NONE;
			r.byte_index = fr_count;
			r.status = ST_TMO;
			r.declared_length = fr_len;
			restart_hunt();
			return r;
		end
		nxt = PH_H0;
		fin = 1'b0;
		rl = ROLE_DISCARD;
		idx = 8'd0;
		case (fr_phase)
			PH_H0: begin
				if (b == HDR_SYNC) begin
					rl = ROLE_HEADER;
					nxt = PH_H1;
				end
			end
			PH_H1: begin
				if (b == HDR_SYNC) begin
					rl = ROLE_HEADER;
					idx = 8'd1;
					nxt = PH_H2;
				end
			end
			PH_H2: begin
				// extra sync bytes hold position 1
				if (b == HDR_LAST) begin
					rl = ROLE_HEADER;
					idx = 8'd2;
					nxt = PH_RES;
				end else if (b == HDR_SYNC) begin
					rl = ROLE_HEADER;
					idx = 8'd1;
					nxt = PH_H2;
				end
			end
			default: begin
				rl = role_t'(fr_phase - 4'd1);
				idx = fr_count;
				if (fr_phase == PH_LLO)
					fr_len = {8'h00, b};
				else if (fr_phase == PH_LHI)
					fr_len = {b, fr_len[7:0]};
				eff = (fr_len < MIN_LEN) ? MIN_LEN : fr_len;
				case (fr_phase)
					PH_INS: nxt = (eff == MIN_LEN) ? PH_CK1 : PH_PAR;
					PH_PAR: nxt = ({9'd0, idx} >= {1'b0, eff} + PAR_OFFSET) ? PH_CK1 : PH_PAR;
					PH_CK2: fin = 1'b1;
					default: nxt = phase_t'(fr_phase + 4'd1);
				endcase
			end
		endcase
		cnt = {1'b0, idx} + 9'd1;
		r.data_byte = b;
		r.role = rl;
		r.byte_index = idx;
		r.status = ST_RUN;
		r.declared_length = fr_len;
		if (cnt >= {1'b0, fr_limit}) begin
			r.status = ST_OVF;
			restart_hunt();
		end else if (fin) begin
			r.status = ST_DONE;
			restart_hunt();
		end else begin
			fr_phase = nxt;
			fr_count = (nxt == PH_H0) ? 8'h00 : cnt[7:0];
			if (nxt == PH_H0)
				fr_len = 16'h0000;
		end
		return r;
	endfunction

	// Sender: offer queued items, hold the payload while stalled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pending_tags.push_back(tag_next_byte(kind, rx_byte));
				tx_gap = tx_idle_en ? $urandom_range(19, 0) : 0;
			end
			if (!(in_valid && in_stall)) begin
				if (tx_gap != 0) begin
					tx_gap = tx_gap - 1;
					in_valid <= 1'b0;
				end else if (rx_stream.size() != 0) begin
					rx_ev_t ev;
					ev = rx_stream.pop_front();
					in_valid <= 1'b1;
					kind <= ev.kind;
					rx_byte <= ev.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here.
	always @(posedge clk) begin
		if (hold_start)
			hold_left <= 200;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	function automatic string tag_str(input res_t t);
		return $sformatf("byte %h role %0d idx %0d st %0d len %h",
			t.data_byte, t.role, t.byte_index, t.status, t.declared_length);
	endfunction

	task automatic report_mismatch(input string what, input res_t want, input res_t got);
		tag_errors++;
		if (tag_errors <= 10)
			$display("%t mismatch (%s): want %s, got %s",
				$realtime, what, tag_str(want), tag_str(got));
	endtask

	// Receiver: take results, compare with the oldest expected tag.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			res_t got;
			res_t want;
			got.data_byte = data_byte;
			got.role = role_t'(role);
			got.byte_index = byte_index;
			got.status = status_t'(status);
			got.declared_length = declared_length;
			if (pending_tags.size() == 0) begin
				want = '0;
				report_mismatch("unexpected", want, got);
			end else begin
				want = pending_tags.pop_front();
				if (got.data_byte !== want.data_byte || got.role !== want.role ||
						got.byte_index !== want.byte_index || got.status !== want.status ||
						got.declared_length !== want.declared_length)
					report_mismatch("field", want, got);
			end
			rx_gap = rx_idle_en ? $urandom_range(19, 0) : 0;
		end else if (rx_gap != 0) begin
			rx_gap = rx_gap - 1;
		end
		out_stall <= (rx_gap != 0) || (hold_left != 0);
	end

	task automatic push_byte(input logic [7:0] b);
		rx_ev_t ev;
		ev.kind = 1'b0;
		ev.b = b;
		rx_stream.push_back(ev);
	endtask

	task automatic push_timeout();
		rx_ev_t ev;
		ev.kind = 1'b1;
		ev.b = 8'($urandom_range(255, 0));
		rx_stream.push_back(ev);
	endtask

	// Push n bytes, most significant first.
	task automatic push_bytes(input logic [127:0] seq, input int n);
		for (int i = n - 1; i >= 0; i--)
			push_byte(seq[i*8 +: 8]);
	endtask

	// One frame with random content; sometimes noisy, broken or cut by a timeout.
	task automatic push_frame(inout int total);
		logic [7:0]  fb[$];
		logic [15:0] len;
		int          roll;
		int          npar;
		int          cut;
		if ($urandom_range(99, 0) < 15)
			repeat ($urandom_range(3, 1))
				fb.push_back($urandom_range(99, 0) < 30 ? HDR_SYNC : 8'($urandom_range(255, 0)));
		fb.push_back(HDR_SYNC);
		if ($urandom_range(99, 0) < 20)
			repeat ($urandom_range(3, 1))
				fb.push_back(HDR_SYNC);
		fb.push_back(HDR_SYNC);
		fb.push_back($urandom_range(99, 0) < 8 ? 8'($urandom_range(255, 0)) : HDR_LAST);
		roll = $urandom_range(99, 0);
		if (roll < 10)
			len = 16'($urandom_range(3, 0));
		else if (roll < 75)
			len = 16'($urandom_range(12, 4));
		else if (roll < 95)
			len = 16'($urandom_range(40, 13));
		else
			len = 16'($urandom_range(65535, 0));
		fb.push_back(8'($urandom_range(255, 0)));
		fb.push_back(8'($urandom_range(255, 0)));
		fb.push_back(len[7:0]);
		fb.push_back(len[15:8]);
		fb.push_back(8'($urandom_range(255, 0)));
		npar = (len < 3) ? 0 : int'(len) - 3;
		if (npar > 252)
			npar = 252;
		repeat (npar)
			fb.push_back(8'($urandom_range(255, 0)));
		fb.push_back(8'($urandom_range(255, 0)));
		fb.push_back(8'($urandom_range(255, 0)));
		cut = fb.size();
		if ($urandom_range(99, 0) < 6)
			cut = $urandom_range(fb.size() - 1, 0);
		for (int i = 0; i < cut; i++)
			push_byte(fb[i]);
		total += cut;
		if (cut != fb.size() || $urandom_range(99, 0) < 3) begin
			push_timeout();
			total++;
		end
	endtask

	task automatic run_frames(input int n);
		int total;
		total = 0;
		while (total < n)
			push_frame(total);
	endtask

	task automatic wait_idle();
		while (rx_stream.size() != 0 || in_valid || pending_tags.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		fr_limit = v;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// broken headers, timeout while hunting, extra sync, short length,
		// timeout inside a frame
		push_bytes(128'h12, 1);
		push_bytes(128'hFF_00, 2);
		push_bytes(128'hFF_FF_7E, 3);
		push_timeout();
		push_bytes(128'hFF_FF_FF_FD_00_01_02_00_03_AA_BB, 11);
		push_bytes(128'hFF_FF_FD_00_FE_05_00_55_01, 9);
		push_timeout();
		wait_idle();

		// smallest limit: a minimal frame overflows at position 7
		write_limit(8'd8);
		push_bytes(128'hFF_FF_FD_00_01_03_00_02_CC_DD, 10);
		run_frames(120);
		wait_idle();

		// fill the block while the receiver holds off
		write_limit(8'd255);
		tx_idle_en = 1'b0;
		run_frames(300);
		@(posedge clk);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		wait_idle();

		write_limit(8'd9);
		rx_idle_en = 1'b0;
		run_frames(100);
		wait_idle();

		write_limit(8'd254);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		run_frames(300);
		wait_idle();

		repeat (4) begin
			write_limit(8'($urandom_range(255, 8)));
			run_frames(150);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (tag_errors == 0 && pending_tags.size() == 0)
			$display("servo_bus_packet_deframer_top_tb OK");
		else
			$display("servo_bus_packet_deframer_top_tb NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("servo_bus_packet_deframer_top_tb NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/sbpd_pkg.sv
rtl/core/sbpd_fsm.sv
rtl/core/servo_bus_packet_deframer_top.sv
rtl/core/sbpd_checker.sv
dv/servo_bus_packet_deframer_top_tb.sv
